[rtl/fjpe_pkg.sv]
package fjpe_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_VAL     = 3'd1;
  localparam logic [2:0] KIND_DONE    = 3'd2;
  localparam logic [2:0] KIND_DISCARD = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  // Byte codes the parser looks for.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text;
    logic       last;
  } res_t;

  // All results caused by one input byte; only the first cnt entries count.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [MAX_RES-1:0] item;
  } step_t;

  function automatic logic is_ws(input logic [7:0] b);
    return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
  endfunction

  function automatic logic is_term(input logic [7:0] b);
    return (b == CH_COMMA) || (b == CH_RBRACE) || (b == CH_RBRACK) || is_ws(b);
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == CH_N) begin
      r = CH_LF;
    end else if (b == CH_T) begin
      r = CH_TAB;
    end
    return r;
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] b);
    res_t r;
    r.kind = kind;
    r.text = ((kind == KIND_KEY) || (kind == KIND_VAL)) ? b : 8'd0;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

[rtl/fjpe_parse.sv]
module fjpe_parse #(
  parameter int unsigned MAX_NEST = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  output fjpe_pkg::step_t     step
);

  localparam int unsigned DEPTH_W = $clog2(MAX_NEST + 1);

  typedef enum logic [3:0] {
    PH_SEEK,
    PH_KEY,
    PH_AFTER_KEY,
    PH_KEY_ESC,
    PH_AFTER_COL,
    PH_VSTR,
    PH_VSTR_ESC,
    PH_NEST,
    PH_VBARE
  } phase_t;

  phase_t                  phase_r;
  phase_t                  phase_nxt;
  phase_t                  phase_mid;
  logic [DEPTH_W-1:0]      depth_r;
  logic [DEPTH_W-1:0]      depth_nxt;
  logic [DEPTH_W-1:0]      depth_dec;
  logic [1:0]              n_c;
  fjpe_pkg::res_t [fjpe_pkg::MAX_RES-1:0] items_c;

  assign depth_dec = (depth_r != '0) ? depth_r - DEPTH_W'(1) : depth_r;

  always_comb begin
    phase_mid = phase_r;
    phase_nxt = phase_r;
    depth_nxt = depth_r;
    items_c   = '0;
    n_c       = 2'd0;

    case (phase_r)
      PH_KEY: begin
        if (data_byte == fjpe_pkg::CH_QUOTE) begin
          phase_mid = PH_AFTER_KEY;
        end else if ((data_byte == fjpe_pkg::CH_BSLASH) && !final_byte) begin
          phase_mid = PH_KEY_ESC;
        end else begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_KEY, data_byte);
          n_c = n_c + 2'd1;
        end
      end
      PH_KEY_ESC: begin
        items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_KEY, fjpe_pkg::unescape(data_byte));
        n_c = n_c + 2'd1;
        phase_mid = PH_KEY;
      end
      PH_AFTER_KEY, PH_AFTER_COL: begin
        if (fjpe_pkg::is_ws(data_byte)) begin
          phase_mid = phase_r;
        end else if ((phase_r == PH_AFTER_KEY) && (data_byte == fjpe_pkg::CH_COLON)) begin
          phase_mid = PH_AFTER_COL;
        end else if (data_byte == fjpe_pkg::CH_QUOTE) begin
          phase_mid = PH_VSTR;
        end else if ((data_byte == fjpe_pkg::CH_LBRACE) ||
                     (data_byte == fjpe_pkg::CH_LBRACK)) begin
          // Nested values are skipped and their key is dropped.
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_DISCARD, 8'd0);
          n_c = n_c + 2'd1;
          depth_nxt = DEPTH_W'(1);
          phase_mid = PH_NEST;
        end else if (fjpe_pkg::is_term(data_byte)) begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_DONE, 8'd0);
          n_c = n_c + 2'd1;
          phase_mid = PH_SEEK;
        end else begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_VAL, data_byte);
          n_c = n_c + 2'd1;
          phase_mid = PH_VBARE;
        end
      end
      PH_VSTR: begin
        if (data_byte == fjpe_pkg::CH_QUOTE) begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_DONE, 8'd0);
          n_c = n_c + 2'd1;
          phase_mid = PH_SEEK;
        end else if ((data_byte == fjpe_pkg::CH_BSLASH) && !final_byte) begin
          phase_mid = PH_VSTR_ESC;
        end else begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_VAL, data_byte);
          n_c = n_c + 2'd1;
        end
      end
      PH_VSTR_ESC: begin
        items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_VAL, fjpe_pkg::unescape(data_byte));
        n_c = n_c + 2'd1;
        phase_mid = PH_VSTR;
      end
      PH_NEST: begin
        if ((data_byte == fjpe_pkg::CH_LBRACE) || (data_byte == fjpe_pkg::CH_LBRACK)) begin
          if (depth_r < DEPTH_W'(MAX_NEST)) begin
            depth_nxt = depth_r + DEPTH_W'(1);
          end
        end else if ((data_byte == fjpe_pkg::CH_RBRACE) ||
                     (data_byte == fjpe_pkg::CH_RBRACK)) begin
          depth_nxt = depth_dec;
          if (depth_dec == '0) begin
            phase_mid = PH_SEEK;
          end
        end
      end
      PH_VBARE: begin
        if (fjpe_pkg::is_term(data_byte)) begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_DONE, 8'd0);
          n_c = n_c + 2'd1;
          phase_mid = PH_SEEK;
        end else begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_VAL, data_byte);
          n_c = n_c + 2'd1;
        end
      end
      default: begin
        phase_mid = (data_byte == fjpe_pkg::CH_QUOTE) ? PH_KEY : PH_SEEK;
      end
    endcase

    phase_nxt = phase_mid;

    // At the end of the body an open value completes, an open key is dropped, and an end mark always follows.
    if (final_byte) begin
      case (phase_mid)
        PH_VSTR, PH_VSTR_ESC, PH_VBARE: begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_DONE, 8'd0);
          n_c = n_c + 2'd1;
        end
        PH_KEY, PH_KEY_ESC, PH_AFTER_KEY, PH_AFTER_COL: begin
          items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_DISCARD, 8'd0);
          n_c = n_c + 2'd1;
        end
        default: begin
        end
      endcase
      items_c[n_c] = fjpe_pkg::mk_res(fjpe_pkg::KIND_END, 8'd0);
      n_c = n_c + 2'd1;
      phase_nxt = PH_SEEK;
      depth_nxt = '0;
    end

    if (n_c != 2'd0) begin
      items_c[n_c - 2'd1].last = 1'b1;
    end
  end

  assign step.cnt  = n_c;
  assign step.item = items_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      depth_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      depth_r <= depth_nxt;
    end
  end

`ifndef SYNTHESIS
  a_depth_only_nested: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r != '0) |-> (phase_r == PH_NEST))
    else $error("nesting depth is nonzero outside a nested value");

  a_nested_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NEST) |-> (depth_r != '0))
    else $error("nested value open with zero depth");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && final_byte) |=> ((phase_r == PH_SEEK) && (depth_r == '0)))
    else $error("parser not back to seek after the last byte of a body");
`endif

endmodule

[rtl/flat_json_pair_extractor_unit.sv]
// Results of an accepted byte enter a registered queue whose head drives the output.
// Throughput: one byte per cycle while each byte yields at most one result and out_tready
// stays high; a byte that yields two or three results holds the input until the queue is
// down to one entry, since the single output port drains the queue one entry per cycle.
// Reset: synchronous, active low; it empties the result queue and returns the parser to
// seeking a key with zero nesting depth.
module flat_json_pair_extractor_unit #(
  parameter int unsigned MAX_NEST = 255
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte

  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] text_byte
  output logic [2:0] out_tuser,  // [2:0] kind
  output logic       out_tlast   // run_last
);

  localparam int unsigned QDEPTH = 4;

  fjpe_pkg::step_t        step;
  fjpe_pkg::res_t         queue_r [QDEPTH];
  logic [1:0]             wr_ptr_r;
  logic [1:0]             wr_ptr_nxt;
  logic [1:0]             rd_ptr_r;
  logic [1:0]             rd_ptr_nxt;
  logic [2:0]             count_r;
  logic [2:0]             count_nxt;
  logic [1:0]             push_cnt;
  logic                   in_acc;
  logic                   out_acc;
  fjpe_pkg::res_t         head;

  // Room for a full three-result transaction must be there before a byte is taken.
  assign in_tready = (count_r <= 3'd1);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign push_cnt  = in_acc ? step.cnt : 2'd0;

  fjpe_parse #(
    .MAX_NEST(MAX_NEST)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .data_byte (in_tdata),
    .final_byte(in_tlast),
    .step      (step)
  );

  assign head       = queue_r[rd_ptr_r];
  assign out_tvalid = (count_r != 3'd0);
  assign out_tdata  = head.text;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  assign wr_ptr_nxt = wr_ptr_r + push_cnt;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, out_acc};
  assign count_nxt  = count_r + {1'b0, push_cnt} - {2'b00, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(fjpe_pkg::MAX_RES); i++) begin
      if (2'(i) < push_cnt) begin
        queue_r[wr_ptr_r + 2'(i)] <= step.item[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == fjpe_pkg::KIND_KEY) || (out_tuser == fjpe_pkg::KIND_VAL) ||
                   (out_tuser == fjpe_pkg::KIND_DONE) ||
                   (out_tuser == fjpe_pkg::KIND_DISCARD) ||
                   (out_tuser == fjpe_pkg::KIND_END))
    else $error("result kind out of range");

  a_mark_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != fjpe_pkg::KIND_KEY) && (out_tuser != fjpe_pkg::KIND_VAL))
      |-> (out_tdata == 8'd0))
    else $error("mark result carries a nonzero text byte");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == fjpe_pkg::KIND_END)) |-> out_tlast)
    else $error("end-of-body mark not flagged as the last result of its byte");
`endif

endmodule

[tb/sv/tb_flat_json_pair_extractor_unit.sv]
`timescale 1ns / 1ps

module tb_flat_json_pair_extractor_unit;

  localparam int unsigned NEST_LIMIT = 255;
  localparam int unsigned RANDOM_BYTES = 200;
  localparam int unsigned CALM_BYTES = 160;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef enum logic [3:0] {
    P_SEEK, P_KEY, P_AFTER_KEY, P_KEY_ESC, P_AFTER_COLON,
    P_STR, P_STR_ESC, P_NEST, P_BARE
  } phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  bit          calm = 1'b0;
  bit          deep_sent = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_rate = 0;
  int unsigned random_sent = 0;
  logic [7:0]  body_q[$];

  function automatic bit is_blank(logic [7:0] b);
    return b == fjpe_pkg::CH_SPACE || (b >= 8'h09 && b <= fjpe_pkg::CH_CR);
  endfunction

  function automatic bit ends_bare(logic [7:0] b);
    return is_blank(b) || b == fjpe_pkg::CH_COMMA || b == fjpe_pkg::CH_RBRACE ||
           b == fjpe_pkg::CH_RBRACK;
  endfunction

  class pair_scoreboard;
    phase_t          phase;
    int unsigned     depth;
    fjpe_pkg::res_t  expected_q[$];
    fjpe_pkg::res_t  step_q[$];
    int              errors;

    function new();
      phase = P_SEEK;
      depth = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] b);
      fjpe_pkg::res_t r;
      r.kind = kind;
      r.text = (kind == fjpe_pkg::KIND_KEY || kind == fjpe_pkg::KIND_VAL) ? b : 8'h00;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function logic [7:0] decode_escape(logic [7:0] b);
      if (b == fjpe_pkg::CH_N) return fjpe_pkg::CH_LF;
      if (b == fjpe_pkg::CH_T) return fjpe_pkg::CH_TAB;
      return b;
    endfunction

    // The first byte of a value selects its form.
    function void open_value(logic [7:0] b);
      if (b == fjpe_pkg::CH_QUOTE) begin
        phase = P_STR;
      end else if (b == fjpe_pkg::CH_LBRACE || b == fjpe_pkg::CH_LBRACK) begin
        emit(fjpe_pkg::KIND_DISCARD, 8'h00);
        depth = 1;
        phase = P_NEST;
      end else if (ends_bare(b)) begin
        emit(fjpe_pkg::KIND_DONE, 8'h00);
        phase = P_SEEK;
      end else begin
        emit(fjpe_pkg::KIND_VAL, b);
        phase = P_BARE;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      step_q.delete();
      case (phase)
        P_KEY: begin
          if (b == fjpe_pkg::CH_QUOTE) phase = P_AFTER_KEY;
          else if (b == fjpe_pkg::CH_BSLASH && !fin) phase = P_KEY_ESC;
          else emit(fjpe_pkg::KIND_KEY, b);
        end
        P_KEY_ESC: begin
          emit(fjpe_pkg::KIND_KEY, decode_escape(b));
          phase = P_KEY;
        end
        P_AFTER_KEY: begin
          if (b == fjpe_pkg::CH_COLON) phase = P_AFTER_COLON;
          else if (!is_blank(b)) open_value(b);
        end
        P_AFTER_COLON: begin
          if (!is_blank(b)) open_value(b);
        end
        P_STR: begin
          if (b == fjpe_pkg::CH_QUOTE) begin
            emit(fjpe_pkg::KIND_DONE, 8'h00);
            phase = P_SEEK;
          end else if (b == fjpe_pkg::CH_BSLASH && !fin) begin
            phase = P_STR_ESC;
          end else begin
            emit(fjpe_pkg::KIND_VAL, b);
          end
        end
        P_STR_ESC: begin
          emit(fjpe_pkg::KIND_VAL, decode_escape(b));
          phase = P_STR;
        end
        P_NEST: begin
          if (b == fjpe_pkg::CH_LBRACE || b == fjpe_pkg::CH_LBRACK) begin
            if (depth < NEST_LIMIT) depth++;
          end else if (b == fjpe_pkg::CH_RBRACE || b == fjpe_pkg::CH_RBRACK) begin
            if (depth > 0) depth--;
            if (depth == 0) phase = P_SEEK;
          end
        end
        P_BARE: begin
          if (ends_bare(b)) begin
            emit(fjpe_pkg::KIND_DONE, 8'h00);
            phase = P_SEEK;
          end else begin
            emit(fjpe_pkg::KIND_VAL, b);
          end
        end
        default: begin
          phase = (b == fjpe_pkg::CH_QUOTE) ? P_KEY : P_SEEK;
        end
      endcase
      if (fin) begin
        case (phase)
          P_STR, P_STR_ESC, P_BARE: emit(fjpe_pkg::KIND_DONE, 8'h00);
          P_KEY, P_KEY_ESC, P_AFTER_KEY, P_AFTER_COLON: emit(fjpe_pkg::KIND_DISCARD, 8'h00);
          default: ;
        endcase
        emit(fjpe_pkg::KIND_END, 8'h00);
        phase = P_SEEK;
        depth = 0;
      end
      if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [2:0] kind, logic [7:0] text, logic last);
      fjpe_pkg::res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h last %0b", kind, text, last));
      end else begin
        want = expected_q.pop_front();
        if (kind !== want.kind)
          report($sformatf("kind %0d, expected %0d", kind, want.kind));
        if (text !== want.text)
          report($sformatf("text byte %02h, expected %02h", text, want.text));
        if (last !== want.last)
          report($sformatf("run last %0b, expected %0b", last, want.last));
      end
    endtask
  endclass

  pair_scoreboard sb = new();

  flat_json_pair_extractor_unit #(.MAX_NEST(NEST_LIMIT)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[flat_json_pair_extractor_unit] ERROR");
      $finish;
    end
  end

  // Receiver: drops out_tready in bursts of random length until the calm tail.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  function automatic void push_str(string s);
    foreach (s[i]) body_q.push_back(s[i]);
  endfunction

  function automatic void push_blanks();
    int unsigned n;
    int unsigned r;
    n = $urandom_range(0, 2);
    repeat (n) begin
      r = $urandom_range(0, 5);
      body_q.push_back(r == 5 ? fjpe_pkg::CH_SPACE : 8'(8'h09 + r));
    end
  endfunction

  // Quoted text with random escapes; the quotes themselves are not pushed.
  function automatic void push_text();
    logic [7:0] b;
    int unsigned n;
    n = $urandom_range(0, 5);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) begin
        body_q.push_back(fjpe_pkg::CH_BSLASH);
        case ($urandom_range(0, 4))
          0: b = fjpe_pkg::CH_N;
          1: b = fjpe_pkg::CH_T;
          2: b = fjpe_pkg::CH_QUOTE;
          3: b = fjpe_pkg::CH_BSLASH;
          default: b = 8'($urandom_range(0, 255));
        endcase
      end else begin
        do b = 8'($urandom_range(0, 255));
        while (b == fjpe_pkg::CH_QUOTE || b == fjpe_pkg::CH_BSLASH);
      end
      body_q.push_back(b);
    end
  endfunction

  function automatic void push_nested();
    int unsigned lvl;
    int unsigned steps;
    logic [7:0] b;
    lvl = 1;
    steps = 0;
    body_q.push_back($urandom_range(0, 1) ? fjpe_pkg::CH_LBRACE : fjpe_pkg::CH_LBRACK);
    while (lvl > 0) begin
      steps++;
      if (steps > 10) begin
        body_q.push_back($urandom_range(0, 1) ? fjpe_pkg::CH_RBRACE : fjpe_pkg::CH_RBRACK);
        lvl--;
      end else begin
        case ($urandom_range(0, 3))
          0: if (lvl < 4) begin
            body_q.push_back($urandom_range(0, 1) ? fjpe_pkg::CH_LBRACE : fjpe_pkg::CH_LBRACK);
            lvl++;
          end
          1: begin
            body_q.push_back($urandom_range(0, 1) ? fjpe_pkg::CH_RBRACE : fjpe_pkg::CH_RBRACK);
            lvl--;
          end
          default: begin
            do b = 8'($urandom_range(0, 255));
            while (b == fjpe_pkg::CH_LBRACE || b == fjpe_pkg::CH_LBRACK ||
                   b == fjpe_pkg::CH_RBRACE || b == fjpe_pkg::CH_RBRACK);
            body_q.push_back(b);
          end
        endcase
      end
    end
  endfunction

  // Bare value, possibly empty; quotes may appear inside it.
  function automatic void push_bare();
    logic [7:0] b;
    int unsigned n;
    n = $urandom_range(0, 4);
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (ends_bare(b));
      body_q.push_back(b);
    end
    case ($urandom_range(0, 3))
      0: body_q.push_back(fjpe_pkg::CH_COMMA);
      1: body_q.push_back(fjpe_pkg::CH_RBRACE);
      2: body_q.push_back(fjpe_pkg::CH_RBRACK);
      default: body_q.push_back($urandom_range(0, 1) ? fjpe_pkg::CH_SPACE :
                                8'($urandom_range(9, 13)));
    endcase
  endfunction

  function automatic void build_body();
    int unsigned pairs;
    int unsigned cut;
    body_q.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(0, 255)));
    end
    pairs = $urandom_range(1, 3);
    repeat (pairs) begin
      body_q.push_back(fjpe_pkg::CH_QUOTE);
      push_text();
      body_q.push_back(fjpe_pkg::CH_QUOTE);
      push_blanks();
      if ($urandom_range(0, 3) != 0) body_q.push_back(fjpe_pkg::CH_COLON);
      push_blanks();
      case ($urandom_range(0, 3))
        0: begin
          body_q.push_back(fjpe_pkg::CH_QUOTE);
          push_text();
          body_q.push_back(fjpe_pkg::CH_QUOTE);
        end
        1: push_nested();
        default: push_bare();
      endcase
      if ($urandom_range(0, 1) == 0) body_q.push_back(fjpe_pkg::CH_COMMA);
      push_blanks();
    end
    // A broken body ends at an arbitrary byte.
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, body_q.size());
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
  endfunction

  task automatic send_body();
    foreach (body_q[i]) begin
      if (!calm && gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= body_q[i];
      in_tlast  <= (i == body_q.size() - 1);
      do @(posedge clk); while (!in_tready);
      sb.note_byte(body_q[i], i == body_q.size() - 1);
    end
    body_q.delete();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Key and value escapes, colon, and a quoted value.
    gap_rate = 2;
    push_str("\"\\n\":\"\\t\\q\"");
    send_body();
    // Nested value right after the key: its key is discarded.
    push_str("\"a\"[]");
    send_body();
    // Comma where a value starts, then a backslash as the final byte of a key.
    push_str("\"b\",x\"\\");
    send_body();
    // Extreme bytes, a bare value holding a quote, closed at the end of the body.
    body_q.push_back(fjpe_pkg::CH_QUOTE);
    body_q.push_back(8'hFF);
    body_q.push_back(fjpe_pkg::CH_QUOTE);
    body_q.push_back(fjpe_pkg::CH_SPACE);
    body_q.push_back(8'h00);
    body_q.push_back(fjpe_pkg::CH_QUOTE);
    send_body();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);

    while (random_sent < RANDOM_BYTES) begin
      if (random_sent >= CALM_BYTES) calm = 1'b1;
      gap_rate = $urandom_range(0, 3);
      if (random_sent >= 80 && !deep_sent) begin
        // Nesting deeper than the counter can hold; the closes that follow
        // return to seeking only if the count saturated.
        push_str("\"d\":");
        repeat (NEST_LIMIT + 3) begin
          body_q.push_back($urandom_range(0, 1) ? fjpe_pkg::CH_LBRACE : fjpe_pkg::CH_LBRACK);
        end
        repeat (NEST_LIMIT) begin
          body_q.push_back($urandom_range(0, 1) ? fjpe_pkg::CH_RBRACE : fjpe_pkg::CH_RBRACK);
        end
        push_str("\"e\":7,");
        deep_sent = 1'b1;
        random_sent += 20;
      end else begin
        build_body();
        random_sent += body_q.size();
      end
      send_body();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[flat_json_pair_extractor_unit] OK");
    end else begin
      $display("[flat_json_pair_extractor_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fjpe_pkg.sv
rtl/fjpe_parse.sv
rtl/flat_json_pair_extractor_unit.sv
tb/sv/tb_flat_json_pair_extractor_unit.sv
